// File: hw/rtl/color_keyed_sprite_blit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the color-keyed sprite blitter
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COLOR_KEYED_SPRITE_BLIT_MACROS_SVH
`define COLOR_KEYED_SPRITE_BLIT_MACROS_SVH

// Same-cycle implication checked at every rising edge outside reset.
`define CKB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked at every rising edge outside reset.
`define CKB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/ckblit_pkg.sv
// ----------------------------------------------------------------------------
// ckblit_pkg
// Types, register indexes and helpers shared by the sprite blitter files.
// ----------------------------------------------------------------------------
`default_nettype none

package ckblit_pkg;

	// Configuration port address width: eight word registers.
	localparam int CFG_ADDR_W = 5;

	// Register indexes, in register map order.
	typedef enum logic [2:0] {
		REG_DEST_X     = 3'd0,
		REG_DEST_Y     = 3'd1,
		REG_SRC_STRIDE = 3'd2,
		REG_SRC_OFF_X  = 3'd3,
		REG_SRC_OFF_Y  = 3'd4,
		REG_RECT_W     = 3'd5,
		REG_RECT_H     = 3'd6,
		REG_KEY_COLOR  = 3'd7
	} reg_idx_t;

	// Current blit configuration as seen by the datapath.
	typedef struct packed {
		logic [11:0] dest_x;
		logic [11:0] dest_y;
		logic [11:0] src_stride;
		logic [11:0] src_off_x;
		logic [11:0] src_off_y;
		logic [8:0]  rect_w;
		logic [8:0]  rect_h;
		logic [15:0] key_color;
	} cfg_t;

	// Reset values of the registers.
	localparam logic [11:0] DEST_X_RST     = 12'd0;
	localparam logic [11:0] DEST_Y_RST     = 12'd0;
	localparam logic [11:0] SRC_STRIDE_RST = 12'd1;
	localparam logic [11:0] SRC_OFF_X_RST  = 12'd0;
	localparam logic [11:0] SRC_OFF_Y_RST  = 12'd0;
	localparam logic [8:0]  RECT_W_RST     = 9'd1;
	localparam logic [8:0]  RECT_H_RST     = 9'd1;
	localparam logic [15:0] KEY_COLOR_RST  = 16'hF81F;

	// Largest window side in pixels.
	localparam logic [8:0] RECT_MAX = 9'd256;

	// A window side of zero acts as one, and anything above the maximum as the maximum.
	function automatic logic [8:0] clamp_size(input logic [8:0] v);
		logic [8:0] r;
		if (v == 9'd0) begin
			r = 9'd1;
		end else if (v > RECT_MAX) begin
			r = RECT_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ckblit_regs.sv
// ----------------------------------------------------------------------------
// ckblit_regs
// APB-style configuration registers of the sprite blitter, with read back.
// ----------------------------------------------------------------------------
`default_nettype none

module ckblit_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [ckblit_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                      pwdata,
	output logic      [31:0]                      prdata,
	output logic                                  pready,
	output ckblit_pkg::cfg_t                      cfg
);
	import ckblit_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_x     <= DEST_X_RST;
			cfg_q.dest_y     <= DEST_Y_RST;
			cfg_q.src_stride <= SRC_STRIDE_RST;
			cfg_q.src_off_x  <= SRC_OFF_X_RST;
			cfg_q.src_off_y  <= SRC_OFF_Y_RST;
			cfg_q.rect_w     <= RECT_W_RST;
			cfg_q.rect_h     <= RECT_H_RST;
			cfg_q.key_color  <= KEY_COLOR_RST;
		end else if (wr_en && pready) begin
			unique case (idx)
				REG_DEST_X:     cfg_q.dest_x     <= pwdata[11:0];
				REG_DEST_Y:     cfg_q.dest_y     <= pwdata[11:0];
				REG_SRC_STRIDE: cfg_q.src_stride <= pwdata[11:0];
				REG_SRC_OFF_X:  cfg_q.src_off_x  <= pwdata[11:0];
				REG_SRC_OFF_Y:  cfg_q.src_off_y  <= pwdata[11:0];
				REG_RECT_W:     cfg_q.rect_w     <= pwdata[8:0];
				REG_RECT_H:     cfg_q.rect_h     <= pwdata[8:0];
				REG_KEY_COLOR:  cfg_q.key_color  <= pwdata[15:0];
			endcase
		end
	end

	// Read back the addressed register, zero extended.
	always_comb begin
		unique case (idx)
			REG_DEST_X:     prdata = {20'd0, cfg_q.dest_x};
			REG_DEST_Y:     prdata = {20'd0, cfg_q.dest_y};
			REG_SRC_STRIDE: prdata = {20'd0, cfg_q.src_stride};
			REG_SRC_OFF_X:  prdata = {20'd0, cfg_q.src_off_x};
			REG_SRC_OFF_Y:  prdata = {20'd0, cfg_q.src_off_y};
			REG_RECT_W:     prdata = {23'd0, cfg_q.rect_w};
			REG_RECT_H:     prdata = {23'd0, cfg_q.rect_h};
			REG_KEY_COLOR:  prdata = {16'd0, cfg_q.key_color};
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/color_keyed_sprite_blit.sv
// ----------------------------------------------------------------------------
// color_keyed_sprite_blit: color-keyed, clipped sprite copy to a canvas
// Output: each result is registered and valid in the cycle after its pixel request is accepted.
// Throughput: one pixel per clock while results are not stalled, held by the single result register.
// Reset: counters to zero, registers to defaults, result register empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "color_keyed_sprite_blit_macros.svh"

module color_keyed_sprite_blit #(
	parameter int CANVAS_W = 320,
	parameter int CANVAS_H = 240
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Configuration port
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [ckblit_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                      pwdata,
	output logic      [31:0]                      prdata,
	output logic                                  pready,
	// Source pixel requests
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [15:0]                      pixel_color,
	// Destination write requests
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [12:0]                    write_x,
	output logic signed [12:0]                    write_y,
	output logic      [15:0]                      write_color,
	output logic                                  write_enable,
	output logic      [23:0]                      next_src_index,
	output logic                                  last
);
	import ckblit_pkg::*;

	localparam logic signed [12:0] CanvasWS = 13'(CANVAS_W);
	localparam logic signed [12:0] CanvasHS = 13'(CANVAS_H);

	cfg_t cfg;

	ckblit_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [7:0]        col_q;
	logic [7:0]        row_q;
	logic              accept;
	logic [8:0]        wend;
	logic [8:0]        hend;
	logic [8:0]        col_inc;
	logic [8:0]        row_inc;
	logic              wrap_col;
	logic              wrap_row;
	logic [7:0]        ncol;
	logic [7:0]        nrow;
	logic [12:0]       src_row;
	logic [24:0]       row_base;
	logic [23:0]       idx;
	logic signed [12:0] wx;
	logic signed [12:0] wy;
	logic              in_canvas;
	logic              en;

	// The result register frees up whenever its request is being taken.
	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	// Window position stepping in raster order.
	always_comb begin
		wend     = clamp_size(cfg.rect_w);
		hend     = clamp_size(cfg.rect_h);
		col_inc  = {1'b0, col_q} + 9'd1;
		row_inc  = {1'b0, row_q} + 9'd1;
		wrap_col = col_inc >= wend;
		wrap_row = wrap_col && (row_inc >= hend);
		ncol     = wrap_col ? 8'd0 : col_inc[7:0];
		if (!wrap_col) begin
			nrow = row_q;
		end else if (wrap_row) begin
			nrow = 8'd0;
		end else begin
			nrow = row_inc[7:0];
		end
	end

	// Sheet index of the next pixel to fetch, modulo 2^24.
	always_comb begin
		src_row  = {1'b0, cfg.src_off_y} + {5'd0, nrow};
		row_base = src_row * cfg.src_stride;
		idx      = row_base[23:0] + {12'd0, cfg.src_off_x} + {16'd0, ncol};
	end

	// Destination position, clipping and the color key test.
	always_comb begin
		wx        = $signed({cfg.dest_x[11], cfg.dest_x}) + $signed({5'd0, col_q});
		wy        = $signed({cfg.dest_y[11], cfg.dest_y}) + $signed({5'd0, row_q});
		in_canvas = !wx[12] && (wx < CanvasWS) && !wy[12] && (wy < CanvasHS);
		en        = in_canvas && (pixel_color != cfg.key_color);
	end

	// Column and row counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 8'd0;
			row_q <= 8'd0;
		end else if (accept) begin
			col_q <= ncol;
			row_q <= nrow;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			write_x        <= wx;
			write_y        <= wy;
			write_color    <= pixel_color;
			write_enable   <= en;
			next_src_index <= idx;
			last           <= wrap_row;
		end
	end

	// The window's final pixel leaves both counters at the window start.
	`CKB_ASSERT_NEXT(a_last_wraps, accept && wrap_row, col_q == 8'd0 && row_q == 8'd0, "counters not cleared after last pixel")
	// An enabled write never lands at a negative canvas position.
	`CKB_ASSERT_NOW(a_en_clipped, out_valid && write_enable, !write_x[12] && !write_y[12], "enabled write outside canvas")
	// A result that is still waiting blocks new pixel requests.
	`CKB_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !accept, "pixel accepted over a stalled result")

endmodule

`default_nettype wire

// File: tb/color_keyed_sprite_blit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// color_keyed_sprite_blit_tb: self-checking bench for the sprite blitter
// Streams source pixels through the blitter under random burst gaps and
// result back-pressure. Each pixel request is run through an in-bench blit
// model, and every destination write request is compared field by field.
// Blit windows, destinations, strides and key colors change between phases,
// which are programmed over the configuration port while the block is idle.
// ----------------------------------------------------------------------------
module color_keyed_sprite_blit_tb;
	import ckblit_pkg::*;

	localparam int CANVAS_W = 320;
	localparam int CANVAS_H = 240;
	localparam int RANDOM_ITEMS = 750;
	localparam int LIMIT_CYCLES = 400000;

	// One expected destination write request.
	typedef struct packed {
		logic [12:0] x;
		logic [12:0] y;
		logic [15:0] color;
		logic        en;
		logic [23:0] src_idx;
		logic        last;
	} canvas_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] pixel_color = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [12:0] write_x;
	logic signed [12:0] write_y;
	logic [15:0] write_color;
	logic write_enable;
	logic [23:0] next_src_index;
	logic last;

	// Blit model state: register shadow and window counters.
	cfg_t blit_cfg;
	logic [7:0] col_cnt;
	logic [7:0] row_cnt;

	logic [15:0] pending_pixels[$];
	canvas_write_t canvas_writes[$];
	logic pix_taken = 1'b0;
	int mismatches = 0;
	int cycle_count = 0;
	int burst_left = 1;
	int gap_left = 0;
	logic [15:0] ready_pat = 16'hFFFF;
	int pat_age = 0;

	color_keyed_sprite_blit #(
		.CANVAS_W(CANVAS_W),
		.CANVAS_H(CANVAS_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel_color(pixel_color),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.write_x(write_x),
		.write_y(write_y),
		.write_color(write_color),
		.write_enable(write_enable),
		.next_src_index(next_src_index),
		.last(last)
	);

	// Clock generation.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Effective window side: zero counts as one, oversize values saturate.
	function automatic int eff_side(input logic [8:0] v);
		int r;
		if (v == 9'd0) begin
			r = 1;
		end else if (v > 9'd256) begin
			r = 256;
		end else begin
			r = int'(v);
		end
		return r;
	endfunction

	// Work out the write request for one source pixel and advance the counters.
	function automatic void blit_pixel(input logic [15:0] pix);
		int wend, hend, col, row, ncol, nrow, wx, wy, dx, dy;
		logic [63:0] idx;
		canvas_write_t w;
		wend = eff_side(blit_cfg.rect_w);
		hend = eff_side(blit_cfg.rect_h);
		col = int'(col_cnt);
		row = int'(row_cnt);
		dx = $signed(blit_cfg.dest_x);
		dy = $signed(blit_cfg.dest_y);
		wx = dx + col;
		wy = dy + row;
		w.last = 1'b0;
		ncol = col + 1;
		nrow = row;
		if (ncol >= wend) begin
			ncol = 0;
			nrow = row + 1;
			if (nrow >= hend) begin
				nrow = 0;
				w.last = 1'b1;
			end
		end
		col_cnt = ncol[7:0];
		row_cnt = nrow[7:0];
		idx = (64'(blit_cfg.src_off_y) + 64'(nrow)) * 64'(blit_cfg.src_stride)
			+ 64'(blit_cfg.src_off_x) + 64'(ncol);
		w.x = wx[12:0];
		w.y = wy[12:0];
		w.color = pix;
		w.en = (wx >= 0 && wx < CANVAS_W && wy >= 0 && wy < CANVAS_H
			&& pix != blit_cfg.key_color);
		w.src_idx = idx[23:0];
		canvas_writes.push_back(w);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp,
		input logic [31:0] act);
		if (exp !== act) begin
			mismatches++;
			$error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
		end
	endfunction

	// Monitor: record pixel requests and check write requests at the rising edge.
	always @(posedge clk) begin
		canvas_write_t w;
		pix_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				blit_pixel(pixel_color);
			end
			if (out_valid && out_ready) begin
				if (canvas_writes.size() == 0) begin
					mismatches++;
					$error("write request with no pixel request outstanding");
				end else begin
					w = canvas_writes.pop_front();
					check_field("write_x", 32'(w.x), 32'(write_x[12:0]));
					check_field("write_y", 32'(w.y), 32'(write_y[12:0]));
					check_field("write_color", 32'(w.color), 32'(write_color));
					check_field("write_enable", 32'(w.en), 32'(write_enable));
					check_field("next_src_index", 32'(w.src_idx), 32'(next_src_index));
					check_field("last", 32'(w.last), 32'(last));
				end
			end
		end
	end

	// Pixel driver: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (!in_valid || pix_taken) begin
			if (gap_left > 0 || pending_pixels.size() == 0) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
				end
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				pixel_color <= pending_pixels.pop_front();
				burst_left = burst_left - 1;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
						: $urandom_range(1, 12);
					gap_left = $urandom_range(0, 6);
				end
			end
		end
	end

	// Write request receiver: stalls on a rotating pattern, re-chosen now and then.
	always @(negedge clk) begin
		if (pat_age == 48) begin
			pat_age = 0;
			case ($urandom_range(0, 3))
				0: ready_pat <= 16'hFFFF;
				1: ready_pat <= 16'h0001 << $urandom_range(0, 15);
				default: ready_pat <= 16'($urandom()) | 16'h0001;
			endcase
		end else begin
			pat_age = pat_age + 1;
			ready_pat <= {ready_pat[0], ready_pat[15:1]};
		end
		out_ready <= ready_pat[0];
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("** color_keyed_sprite_blit: FAILED **");
			$finish;
		end
	end

	// Register write over the configuration port; also updates the shadow.
	task automatic set_reg(input reg_idx_t r, input logic [31:0] v);
		logic [31:0] mask;
		logic [31:0] data;
		case (r)
			REG_RECT_W, REG_RECT_H: mask = 32'h0000_01FF;
			REG_KEY_COLOR: mask = 32'h0000_FFFF;
			default: mask = 32'h0000_0FFF;
		endcase
		data = (v & mask) | ($urandom() & ~mask);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_DEST_X: blit_cfg.dest_x = data[11:0];
			REG_DEST_Y: blit_cfg.dest_y = data[11:0];
			REG_SRC_STRIDE: blit_cfg.src_stride = data[11:0];
			REG_SRC_OFF_X: blit_cfg.src_off_x = data[11:0];
			REG_SRC_OFF_Y: blit_cfg.src_off_y = data[11:0];
			REG_RECT_W: blit_cfg.rect_w = data[8:0];
			REG_RECT_H: blit_cfg.rect_h = data[8:0];
			REG_KEY_COLOR: blit_cfg.key_color = data[15:0];
			default: ;
		endcase
	endtask

	// Hold off until every pixel is sent and every write request has come back.
	task automatic wait_blit_idle();
		@(posedge clk);
		while (pending_pixels.size() != 0 || in_valid || canvas_writes.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Random pixel, often the key color and sometimes an extreme.
	function automatic logic [15:0] pick_pixel();
		logic [15:0] p;
		case ($urandom_range(0, 15))
			0, 1, 2, 3: p = blit_cfg.key_color;
			4: p = 16'h0000;
			5: p = 16'hFFFF;
			default: p = 16'($urandom());
		endcase
		return p;
	endfunction

	// Stimulus sequence.
	initial begin
		int rand_items;
		int n, w, h, dx, dy;
		bit first;
		blit_cfg.dest_x = DEST_X_RST;
		blit_cfg.dest_y = DEST_Y_RST;
		blit_cfg.src_stride = SRC_STRIDE_RST;
		blit_cfg.src_off_x = SRC_OFF_X_RST;
		blit_cfg.src_off_y = SRC_OFF_Y_RST;
		blit_cfg.rect_w = RECT_W_RST;
		blit_cfg.rect_h = RECT_H_RST;
		blit_cfg.key_color = KEY_COLOR_RST;
		col_cnt = 8'd0;
		row_cnt = 8'd0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: single-pixel window, extremes and the default key.
		pending_pixels.push_back(16'h0000);
		pending_pixels.push_back(16'hFFFF);
		pending_pixels.push_back(16'hF81F);
		pending_pixels.push_back(16'h07E0);
		wait_blit_idle();

		// Far corners of the destination range, largest source offsets and stride,
		// a zero width and an oversize height, and black as the key.
		set_reg(REG_DEST_X, 32'hFFFF_F800);
		set_reg(REG_DEST_Y, 32'd2047);
		set_reg(REG_SRC_STRIDE, 32'd4095);
		set_reg(REG_SRC_OFF_X, 32'd4095);
		set_reg(REG_SRC_OFF_Y, 32'd4095);
		set_reg(REG_RECT_W, 32'd0);
		set_reg(REG_RECT_H, 32'd511);
		set_reg(REG_KEY_COLOR, 32'h0000);
		pending_pixels.push_back(16'h0000);
		pending_pixels.push_back(16'hFFFF);
		pending_pixels.push_back(16'h1234);
		wait_blit_idle();

		// Zero stride, with the row counter already past a short window.
		set_reg(REG_DEST_X, 32'd0);
		set_reg(REG_DEST_Y, 32'd0);
		set_reg(REG_SRC_STRIDE, 32'd0);
		set_reg(REG_SRC_OFF_X, 32'd0);
		set_reg(REG_SRC_OFF_Y, 32'd0);
		set_reg(REG_RECT_W, 32'd8);
		set_reg(REG_RECT_H, 32'd2);
		set_reg(REG_KEY_COLOR, 32'hFFFF);
		repeat (5) pending_pixels.push_back(pick_pixel());
		wait_blit_idle();

		// Shrink the width under the column counter; clip at right and bottom.
		set_reg(REG_RECT_W, 32'd2);
		set_reg(REG_DEST_X, 32'd318);
		set_reg(REG_DEST_Y, 32'd238);
		set_reg(REG_SRC_STRIDE, 32'd1);
		repeat (6) pending_pixels.push_back(pick_pixel());
		wait_blit_idle();

		// Random phases, each with fresh settings.
		rand_items = 0;
		first = 1'b1;
		while (rand_items < RANDOM_ITEMS) begin
			if (first || $urandom_range(0, 1) == 0) begin
				dx = ($urandom_range(0, 7) == 0)
					? (($urandom_range(0, 1) == 0) ? -2048 : 2047)
					: int'($urandom_range(0, 360)) - 20;
				set_reg(REG_DEST_X, 32'(dx));
			end
			if (first || $urandom_range(0, 1) == 0) begin
				dy = ($urandom_range(0, 7) == 0)
					? (($urandom_range(0, 1) == 0) ? -2048 : 2047)
					: int'($urandom_range(0, 280)) - 20;
				set_reg(REG_DEST_Y, 32'(dy));
			end
			if (first || $urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 9))
					0: set_reg(REG_SRC_STRIDE, 32'd0);
					1: set_reg(REG_SRC_STRIDE, 32'd4095);
					2: set_reg(REG_SRC_STRIDE, $urandom_range(1, 4095));
					default: set_reg(REG_SRC_STRIDE, $urandom_range(1, 600));
				endcase
			end
			if (first || $urandom_range(0, 1) == 0) begin
				set_reg(REG_SRC_OFF_X, ($urandom_range(0, 5) == 0) ? 32'd4095
					: $urandom_range(0, 300));
			end
			if (first || $urandom_range(0, 1) == 0) begin
				set_reg(REG_SRC_OFF_Y, ($urandom_range(0, 5) == 0) ? 32'd4095
					: $urandom_range(0, 4095));
			end
			if (first || $urandom_range(0, 1) == 0) begin
				set_reg(REG_KEY_COLOR, $urandom_range(0, 65535));
			end
			// Window shape: mostly small, now and then a full or oversize side.
			case ($urandom_range(0, 9))
				0: begin
					w = $urandom_range(256, 511);
					h = $urandom_range(1, 2);
				end
				1: begin
					w = 1;
					h = $urandom_range(256, 511);
				end
				2: begin
					w = 0;
					h = $urandom_range(0, 5);
				end
				default: begin
					w = $urandom_range(1, 12);
					h = $urandom_range(1, 6);
				end
			endcase
			set_reg(REG_RECT_W, 32'(w));
			set_reg(REG_RECT_H, 32'(h));
			first = 1'b0;
			n = $urandom_range(1, 2 * eff_side(blit_cfg.rect_w) * eff_side(blit_cfg.rect_h));
			if (n > 300) begin
				n = 300;
			end
			// The last phase stops at the item budget.
			if (n > RANDOM_ITEMS - rand_items) begin
				n = RANDOM_ITEMS - rand_items;
			end
			repeat (n) pending_pixels.push_back(pick_pixel());
			rand_items += n;
			wait_blit_idle();
		end

		if (mismatches == 0 && canvas_writes.size() == 0) begin
			$display("** color_keyed_sprite_blit: PASSED **");
		end else begin
			$display("** color_keyed_sprite_blit: FAILED **");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ckblit_pkg.sv
hw/rtl/ckblit_regs.sv
hw/rtl/color_keyed_sprite_blit.sv
tb/color_keyed_sprite_blit_tb.sv
